// ----- hdl/b64enc_pkg.sv -----
// Shared types, constants and the character encoding function for the base64 stream encoder.
package b64enc_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_CHARS = 4;

   localparam logic [6:0] PAD_CHAR = 7'h3D;

   typedef struct packed {
      logic [MAX_CHARS-1:0][6:0] chars;
      logic [1:0] last_idx;
      logic fin;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] encode_char(input logic [5:0] v);
      logic [6:0] r;
      if (v < 6'd26) begin
         r = 7'(v) + 7'd65;
      end else if (v < 6'd52) begin
         r = 7'(v) + 7'd71;
      end else if (v < 6'd62) begin
         r = 7'(v) - 7'd4;
      end else if (v == 6'd62) begin
         r = 7'd43;
      end else begin
         r = 7'd47;
      end
      return r;
   endfunction

endpackage

// ----- hdl/b64enc_front.sv -----
// Front end: takes a byte, splits it into 6-bit groups and padding, keeps leftover bits.
module b64enc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [7:0]              data_byte,
   input  logic                    final_byte,
   input  logic                    queue_full,
   output logic                    bundle_push,
   output b64enc_pkg::bundle_type  bundle
);

   logic [3:0]  leftover_ff, leftover_in;
   logic [2:0]  pend_count_ff, pend_count_in;
   logic [3:0]  shift;
   logic [3:0]  rem;
   logic [3:0]  mask;
   logic [11:0] acc;
   logic        two;
   logic [5:0]  grp0, grp1;
   logic [2:0]  pos;
   logic        accept;

   assign accept = push && !queue_full;
   assign bundle_push = accept;

   always_comb begin
      shift = {1'b1, pend_count_ff};
      acc = {leftover_ff, data_byte};
      two = pend_count_ff[2];
      rem = two ? shift - 4'd12 : shift - 4'd6;
      grp0 = 6'(acc >> (shift - 4'd6));
      grp1 = 6'(acc >> rem);
      mask = (rem >= 4'd4) ? 4'hF : ((4'd1 << rem) - 4'd1);

      bundle.chars = '0;
      bundle.fin = final_byte;
      bundle.chars[0] = b64enc_pkg::encode_char(grp0);
      pos = 3'd1;
      if (two) begin
         bundle.chars[1] = b64enc_pkg::encode_char(grp1);
         pos = 3'd2;
      end
      if (final_byte) begin
         if (rem == 4'd4) begin
            bundle.chars[pos[1:0]] = b64enc_pkg::encode_char({acc[3:0], 2'b00});
            bundle.chars[2'(pos + 3'd1)] = b64enc_pkg::PAD_CHAR;
            pos = pos + 3'd2;
         end else if (rem == 4'd2) begin
            bundle.chars[pos[1:0]] = b64enc_pkg::encode_char({acc[1:0], 4'b0000});
            bundle.chars[2'(pos + 3'd1)] = b64enc_pkg::PAD_CHAR;
            bundle.chars[2'(pos + 3'd2)] = b64enc_pkg::PAD_CHAR;
            pos = pos + 3'd3;
         end
      end
      bundle.last_idx = 2'(pos - 3'd1);

      if (final_byte) begin
         pend_count_in = 3'd0;
         leftover_in = 4'd0;
      end else begin
         pend_count_in = rem[2:0];
         leftover_in = acc[3:0] & mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff <= 4'd0;
         pend_count_ff <= 3'd0;
      end else if (accept) begin
         leftover_ff <= leftover_in;
         pend_count_ff <= pend_count_in;
      end
   end

`ifndef SYNTHESIS
   a_pend_legal: assert property (@(posedge clock) disable iff (reset)
      pend_count_ff == 3'd0 || pend_count_ff == 3'd2 || pend_count_ff == 3'd4)
      else $error("pending bit count left the 0/2/4 set");
`endif

endmodule

// ----- hdl/b64enc_queue.sv -----
// Short queue of symbol bundles between the front and back ends.
module b64enc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  b64enc_pkg::bundle_type        wr_data,
   input  logic                          rd_en,
   output b64enc_pkg::bundle_type        rd_data,
   output b64enc_pkg::queue_status_type  status
);

   b64enc_pkg::bundle_type entry_ff [b64enc_pkg::QUEUE_DEPTH];
   logic [b64enc_pkg::PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [b64enc_pkg::PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [b64enc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign status.full = (count_ff == b64enc_pkg::COUNT_W'(b64enc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr = wr_en && !status.full;
   assign do_rd = rd_en && !status.empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == b64enc_pkg::PTR_W'(b64enc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == b64enc_pkg::PTR_W'(b64enc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= b64enc_pkg::COUNT_W'(b64enc_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (status.empty || status.full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// ----- hdl/b64enc_back.sv -----
// Back end: steps through each bundle and presents one character per cycle while rsp_pop keeps the output free.
module b64enc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  b64enc_pkg::bundle_type        head,
   input  b64enc_pkg::queue_status_type  qstat,
   output logic                          head_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [6:0]                    rsp_symbol,
   output logic                          rsp_last_symbol
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] symbol_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_end;

   assign load = !qstat.empty && (!rsp_valid_ff || rsp_pop);
   assign at_end = (idx_ff == head.last_idx);
   assign head_pop = load && at_end;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_last_symbol = last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      idx_in = idx_ff;
      if (load) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         symbol_ff <= head.chars[idx_ff];
         last_ff <= head.fin && at_end;
      end
   end

`ifndef SYNTHESIS
   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty |-> (idx_ff <= head.last_idx))
      else $error("character index past end of bundle");
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> (idx_ff == 2'd0))
      else $error("character index not cleared between bundles");
`endif

endmodule

// ----- hdl/base64_stream_encoder_unit.sv -----
// Top level of the base64 stream encoder.
//
// Request side: drive req_data_byte and req_final_byte with req_push; a byte is
// taken at a clock edge where req_push is high and req_full is low. Mark the
// last byte of each message with req_final_byte.
// Result side: while rsp_empty is low, rsp_symbol holds the oldest ASCII
// character (base64 alphabet or '=') and rsp_last_symbol flags the final
// character of a message; assert rsp_pop to take it.
// Path: each byte's bundle is written into the queue, and its characters are then
// loaded in turn into the output register. Each byte yields one to four
// characters, delivered one per cycle while rsp_pop keeps taking them; three bytes
// give four characters, so an unstalled stream is limited by the output register
// at one character per cycle.
// A two-entry queue between the byte splitter and the character sequencer
// absorbs stalls: when rsp_pop stays low, the queue fills and req_full rises;
// nothing is lost.
// Reset (synchronous, active high) empties the queue and output, and clears
// the leftover bits, so the next byte starts a new message.
module base64_stream_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_symbol,
   output logic       rsp_last_symbol
);

   b64enc_pkg::bundle_type        wr_bundle;
   b64enc_pkg::bundle_type        head;
   b64enc_pkg::queue_status_type  qstat;
   logic                          bundle_push;
   logic                          head_pop;

   assign req_full = qstat.full;

   b64enc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .data_byte   (req_data_byte),
      .final_byte  (req_final_byte),
      .queue_full  (qstat.full),
      .bundle_push (bundle_push),
      .bundle      (wr_bundle)
   );

   b64enc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_push),
      .wr_data (wr_bundle),
      .rd_en   (head_pop),
      .rd_data (head),
      .status  (qstat)
   );

   b64enc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .qstat           (qstat),
      .head_pop        (head_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_symbol (rsp_last_symbol)
   );

endmodule

// ----- dv/base64_stream_encoder_unit_tb.sv -----
// Self-checking testbench for the base64 stream encoder: directed and random messages.
`timescale 1ns / 1ps

module base64_stream_encoder_unit_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 16;
   localparam int RANDOM_ITEMS_PER_PHASE = 100;
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [6:0] symbol;
      logic       last;
   } symbol_rec_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_data_byte;
   logic       req_final_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [6:0] rsp_symbol;
   logic       rsp_last_symbol;

   symbol_rec_type expected_symbols[$];
   logic [3:0]  carry_bits;
   logic [2:0]  carry_count;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int          error_count;
   int          cycle_count;

   base64_stream_encoder_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_symbol      (rsp_symbol),
      .rsp_last_symbol (rsp_last_symbol)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [6:0] alphabet_char(input logic [5:0] idx);
      logic [7:0] c;
      c = ALPHABET[8*(63 - int'(idx)) +: 8];
      return c[6:0];
   endfunction

   // Computes the characters one request produces and queues them.
   function automatic void predict_symbols(input logic [7:0] data, input logic fin);
      logic [11:0] acc;
      int          shift;
      int          n;
      logic [6:0]  chars[4];
      symbol_rec_type rec;
      acc = {carry_bits, data};
      shift = int'(carry_count) + 8;
      n = 0;
      while (shift >= 6) begin
         shift -= 6;
         chars[n] = alphabet_char(6'((acc >> shift) & 12'h3F));
         n++;
      end
      if (fin) begin
         if (shift == 4) begin
            chars[n] = alphabet_char({acc[3:0], 2'b00});
            chars[n+1] = b64enc_pkg::PAD_CHAR;
            n += 2;
         end else if (shift == 2) begin
            chars[n] = alphabet_char({acc[1:0], 4'b0000});
            chars[n+1] = b64enc_pkg::PAD_CHAR;
            chars[n+2] = b64enc_pkg::PAD_CHAR;
            n += 3;
         end
         carry_bits = 4'd0;
         carry_count = 3'd0;
      end else begin
         carry_count = 3'(shift);
         carry_bits = 4'(acc & ((12'd1 << shift) - 12'd1));
      end
      for (int i = 0; i < n; i++) begin
         rec.symbol = chars[i];
         rec.last = fin && (i == n - 1);
         expected_symbols.insert(expected_symbols.size(), rec);
      end
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         req_data_byte <= 8'($urandom_range(255));
         req_final_byte <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= data;
      req_final_byte <= fin;
      do @(posedge clock); while (req_full);
      predict_symbols(data, fin);
   endtask

   task automatic wait_for_symbols();
      req_push <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      symbol_rec_type exp_rec;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: unexpected symbol, expected none actual %h last %b",
                        $time, rsp_symbol, rsp_last_symbol);
               error_count++;
            end else begin
               exp_rec = expected_symbols.pop_front();
               if (rsp_symbol !== exp_rec.symbol) begin
                  $display("%0t: symbol mismatch, expected %h actual %h",
                           $time, exp_rec.symbol, rsp_symbol);
                  error_count++;
               end
               if (rsp_last_symbol !== exp_rec.last) begin
                  $display("%0t: last_symbol mismatch, expected %b actual %b",
                           $time, exp_rec.last, rsp_last_symbol);
                  error_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("base64_stream_encoder_unit_tb failed");
      $finish;
   end

   // One, two and three byte messages: two pads, one pad, aligned end.
   task automatic test_padding_cases();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'h00, 1'b1);
      wait_for_symbols();
   endtask

   // Back to back short messages and carries across several groups.
   task automatic test_message_restart();
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7E, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      wait_for_symbols();
   endtask

   task automatic test_random_messages(input int n_items);
      int         sent;
      int         len;
      logic [7:0] data;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(7))
               0: data = 8'h00;
               1: data = 8'hFF;
               default: data = 8'($urandom_range(255));
            endcase
            send_byte(data, i == len - 1);
            sent++;
         end
      end
      wait_for_symbols();
   endtask

   initial begin
      error_count = 0;
      carry_bits = 4'd0;
      carry_count = 3'd0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_push <= 1'b0;
      req_data_byte <= 8'h00;
      req_final_byte <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_padding_cases();
      send_idle_pct = 37;
      recv_stall_pct = 37;
      test_message_restart();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_messages(RANDOM_ITEMS_PER_PHASE);
      send_idle_pct = 49;
      recv_stall_pct = 0;
      test_random_messages(RANDOM_ITEMS_PER_PHASE);
      send_idle_pct = 0;
      recv_stall_pct = 49;
      test_random_messages(RANDOM_ITEMS_PER_PHASE);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      test_random_messages(RANDOM_ITEMS_PER_PHASE);

      wait_for_symbols();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("base64_stream_encoder_unit_tb passed");
      end else begin
         $display("base64_stream_encoder_unit_tb failed");
      end
      $finish;
   end

endmodule
